// ===== hdl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants for the ultrasonic echo ranger: register widths,
// control phases, status codes, configuration indexes and the record that
// travels down the result pipeline.
// ----------------------------------------------------------------------------
package uer_pkg;

   // Width of every configuration register and of the reported pulse width
   localparam int unsigned REG_W     = 20;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned DIST_W    = 15;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_LOW      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POST_LOW     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLDOFF      = 3'd4;

   // Configuration reset values
   localparam logic [REG_W-1:0] PRE_LOW_RST      = 20'd2000;
   localparam logic [REG_W-1:0] TRIGGER_HIGH_RST = 20'd10000;
   localparam logic [REG_W-1:0] POST_LOW_RST     = 20'd2000;
   localparam logic [REG_W-1:0] TIMEOUT_RST      = 20'd1000000;
   localparam logic [REG_W-1:0] HOLDOFF_RST      = 20'd25000;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_ECHO  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_PRE  = 3'd1,
      PH_HIGH = 3'd2,
      PH_POST = 3'd3,
      PH_WAIT = 3'd4,
      PH_MEAS = 3'd5,
      PH_HOLD = 3'd6
   } phase_type;

   typedef struct packed {
      logic [REG_W-1:0] pre_low;
      logic [REG_W-1:0] trigger_high;
      logic [REG_W-1:0] post_low;
      logic [REG_W-1:0] timeout;
      logic [REG_W-1:0] holdoff;
   } cfg_type;

   // Per-tick result, everything but the distance
   typedef struct packed {
      logic                trigger;
      logic                busy;
      logic                done;
      logic [STATUS_W-1:0] status;
      logic [REG_W-1:0]    pulse;
   } res_type;

   // Load enables of the distance pipeline stages
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } pipe_en_type;

endpackage

// ===== hdl/uer_ctrl.sv =====
// ----------------------------------------------------------------------------
// uer_ctrl
// Measurement sequencer: trigger phases, echo rise wait, pulse timing and
// holdoff. Phase and tick counter advance once per accepted tick item.
// ----------------------------------------------------------------------------
module uer_ctrl
   import uer_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 20
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  logic    echo_level,
   input  logic    start_req,
   input  cfg_type cfg,
   output res_type res
);

   localparam int unsigned CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   phase_type              eff_phase;
   logic [COUNT_WIDTH-1:0] eff_count;
   logic [COUNT_WIDTH-1:0] cnt_inc;
   logic [REG_W-1:0]       len;
   logic                   len_hit;
   logic                   tmo_hit;
   logic                   hold_hit;
   phase_type              trig_next;
   phase_type              fin_phase;
   phase_type              start_phase;

   // Entry into the trigger phases skips those of zero length
   always_comb begin
      if (cfg.pre_low != '0) begin
         start_phase = PH_PRE;
      end else if (cfg.trigger_high != '0) begin
         start_phase = PH_HIGH;
      end else if (cfg.post_low != '0) begin
         start_phase = PH_POST;
      end else begin
         start_phase = PH_WAIT;
      end
   end

   // Phase that handles this tick: a start while idle enters at once
   always_comb begin
      if (phase_ff == PH_IDLE && start_req) begin
         eff_phase = start_phase;
         eff_count = '0;
      end else begin
         eff_phase = phase_ff;
         eff_count = count_ff;
      end
   end

   always_comb begin
      case (eff_phase)
         PH_PRE:  len = cfg.pre_low;
         PH_HIGH: len = cfg.trigger_high;
         PH_POST: len = cfg.post_low;
         default: len = REG_W'(1);
      endcase
   end

   always_comb begin
      case (eff_phase)
         PH_PRE: begin
            if (cfg.trigger_high != '0) begin
               trig_next = PH_HIGH;
            end else if (cfg.post_low != '0) begin
               trig_next = PH_POST;
            end else begin
               trig_next = PH_WAIT;
            end
         end
         PH_HIGH: begin
            trig_next = (cfg.post_low != '0) ? PH_POST : PH_WAIT;
         end
         default: trig_next = PH_WAIT;
      endcase
   end

   assign cnt_inc   = eff_count + COUNT_WIDTH'(1);
   assign len_hit   = CMP_W'(cnt_inc) >= CMP_W'(len);
   assign tmo_hit   = CMP_W'(eff_count) >= CMP_W'(cfg.timeout);
   assign hold_hit  = CMP_W'(cnt_inc) >= CMP_W'(cfg.holdoff);
   assign fin_phase = (cfg.holdoff != '0) ? PH_HOLD : PH_IDLE;

   // Next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      if (accept) begin
         case (eff_phase)
            PH_PRE, PH_HIGH, PH_POST: begin
               if (len_hit) begin
                  phase_in = trig_next;
                  count_in = '0;
               end else begin
                  phase_in = eff_phase;
                  count_in = cnt_inc;
               end
            end
            PH_WAIT: begin
               if (echo_level) begin
                  phase_in = PH_MEAS;
                  count_in = COUNT_WIDTH'(1);
               end else if (tmo_hit) begin
                  phase_in = fin_phase;
                  count_in = '0;
               end else begin
                  phase_in = PH_WAIT;
                  count_in = cnt_inc;
               end
            end
            PH_MEAS: begin
               if (echo_level && !tmo_hit) begin
                  count_in = cnt_inc;
               end else begin
                  phase_in = fin_phase;
                  count_in = '0;
               end
            end
            PH_HOLD: begin
               if (hold_hit) begin
                  phase_in = PH_IDLE;
                  count_in = '0;
               end else begin
                  count_in = cnt_inc;
               end
            end
            default: begin
               phase_in = phase_ff;
               count_in = count_ff;
            end
         endcase
      end
   end

   // Tick result
   always_comb begin
      res.trigger = 1'b0;
      res.busy    = 1'b1;
      res.done    = 1'b0;
      res.status  = ST_OK;
      res.pulse   = '0;
      case (eff_phase)
         PH_IDLE: res.busy = 1'b0;
         PH_HIGH: res.trigger = 1'b1;
         PH_WAIT: begin
            if (!echo_level && tmo_hit) begin
               res.done   = 1'b1;
               res.status = ST_NO_ECHO;
            end
         end
         PH_MEAS: begin
            if (!echo_level) begin
               res.done  = 1'b1;
               res.pulse = REG_W'(eff_count);
            end else if (tmo_hit) begin
               res.done   = 1'b1;
               res.status = ST_TOO_LONG;
            end
         end
         default: res.busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/uer_dist.sv =====
// ----------------------------------------------------------------------------
// uer_dist
// Distance from pulse width: pulse*100/CM_DIVISOR by reciprocal multiply,
// back-multiply and one-step correction, saturated to the output width.
// Three register stages, each loaded by its own enable.
// ----------------------------------------------------------------------------
module uer_dist
   import uer_pkg::*;
#(
   parameter int unsigned CM_DIVISOR = 5882
) (
   input  logic              clock,
   input  pipe_en_type       en,
   input  logic [REG_W-1:0]  pulse,
   output logic [DIST_W-1:0] distance
);

   localparam int unsigned DIV_W  = 16;
   localparam int unsigned Q_W    = 27;
   localparam int unsigned P1_W   = REG_W + Q_W;
   localparam int unsigned P2_W   = Q_W + DIV_W;
   localparam logic [DIV_W-1:0] DIV   = DIV_W'(CM_DIVISOR);
   // floor(100 * 2^REG_W / divisor): estimate is exact or one low
   localparam logic [Q_W-1:0]   RECIP = Q_W'((64'd100 << REG_W) / CM_DIVISOR);

   logic [P1_W-1:0]   prod1;
   logic [Q_W-1:0]    q2_ff;
   logic [REG_W-1:0]  pulse2_ff;

   logic [Q_W-1:0]    x_in;
   logic [P2_W-1:0]   prod2_in;
   logic [P2_W-1:0]   prod2_ff;
   logic [Q_W-1:0]    x3_ff;
   logic [Q_W-1:0]    q3_ff;

   logic [P2_W-1:0]   rem;
   logic [Q_W:0]      q_fix;
   logic [DIST_W-1:0] dist_in;
   logic [DIST_W-1:0] dist_ff;

   assign prod1 = P1_W'(pulse) * P1_W'(RECIP);

   always_ff @(posedge clock) begin
      if (en.s2) begin
         q2_ff     <= prod1[P1_W-1:REG_W];
         pulse2_ff <= pulse;
      end
   end

   assign x_in     = Q_W'(pulse2_ff) * Q_W'(100);
   assign prod2_in = P2_W'(q2_ff) * P2_W'(DIV);

   always_ff @(posedge clock) begin
      if (en.s3) begin
         prod2_ff <= prod2_in;
         x3_ff    <= x_in;
         q3_ff    <= q2_ff;
      end
   end

   // Remainder below twice the divisor: one conditional step
   assign rem     = P2_W'(x3_ff) - prod2_ff;
   assign q_fix   = (rem >= P2_W'(DIV)) ? ((Q_W+1)'(q3_ff) + (Q_W+1)'(1))
                                        : (Q_W+1)'(q3_ff);
   assign dist_in = (q_fix > (Q_W+1)'(DIST_MAX)) ? DIST_MAX : q_fix[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (en.s4) begin
         dist_ff <= dist_in;
      end
   end

   assign distance = dist_ff;

endmodule

// ===== hdl/ultrasonic_echo_ranger_top.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_top
// Range controller for a trigger/echo ultrasonic sensor, one item per tick.
// ----------------------------------------------------------------------------
// Each request item is one microsecond tick carrying the sampled echo level
// and a start request; each one produces exactly one response item with the
// trigger pin level, busy, done, status, pulse width and distance for that
// tick. The block takes one item every clock cycle when the response side
// keeps up: the phase and tick counter update for a tick is a single add and
// compare in the sequencer, done at acceptance. Each accepted request moves
// through the registered result stages; the stages behind the first carry the
// distance computation (reciprocal multiply, back-multiply, correction). Each
// stage holds its own valid bit and empty stages fill behind a stalled output,
// so up to four items may be in flight before request stall rises. Registers
// written on the csr port take effect on the next tick, also in the middle of
// a measurement, where a lowered limit ends its phase on that tick; write them
// only while no items are in flight.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_top
   import uer_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 20,
   parameter int unsigned CM_DIVISOR  = 5882
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_echo_level,
   input  logic                 req_start_req,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_trigger_level,
   output logic                 rsp_busy_res,
   output logic                 rsp_done_res,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [REG_W-1:0]     rsp_pulse_us,
   output logic [DIST_W-1:0]    rsp_distance_cm,

   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_data
);

   cfg_type     cfg_ff, cfg_in;

   res_type     res_tick;
   res_type     res1_ff, res2_ff, res3_ff, res4_ff;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        v1_in, v2_in, v3_in, v4_in;
   logic        rdy1, rdy2, rdy3, rdy4;
   logic        accept;
   pipe_en_type dist_en;

   // ---- configuration registers -------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PRE_LOW:      cfg_in.pre_low      = csr_data;
            CSR_TRIGGER_HIGH: cfg_in.trigger_high = csr_data;
            CSR_POST_LOW:     cfg_in.post_low     = csr_data;
            CSR_TIMEOUT:      cfg_in.timeout      = csr_data;
            CSR_HOLDOFF:      cfg_in.holdoff      = csr_data;
            default:          cfg_in = cfg_ff;  // unused index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pre_low      <= PRE_LOW_RST;
         cfg_ff.trigger_high <= TRIGGER_HIGH_RST;
         cfg_ff.post_low     <= POST_LOW_RST;
         cfg_ff.timeout      <= TIMEOUT_RST;
         cfg_ff.holdoff      <= HOLDOFF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- pipeline flow control ---------------------------------------------
   // A stage loads when it is empty or its content moves on this cycle.
   assign rdy4 = !v4_ff || !rsp_stall;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_stall = !rdy1;
   assign accept    = req_valid && rdy1;

   assign v1_in = rdy1 ? req_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff     : v2_ff;
   assign v3_in = rdy3 ? v2_ff     : v3_ff;
   assign v4_in = rdy4 ? v3_ff     : v4_ff;

   assign dist_en.s2 = rdy2;
   assign dist_en.s3 = rdy3;
   assign dist_en.s4 = rdy4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // ---- sequencer: state advances only on an accepted tick ----------------
   uer_ctrl #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .echo_level (req_echo_level),
      .start_req  (req_start_req),
      .cfg        (cfg_ff),
      .res        (res_tick)
   );

   // ---- result pipeline: carry the tick result alongside the distance -----
   always_ff @(posedge clock) begin
      if (rdy1) begin
         res1_ff <= res_tick;
      end
      if (rdy2) begin
         res2_ff <= res1_ff;
      end
      if (rdy3) begin
         res3_ff <= res2_ff;
      end
      if (rdy4) begin
         res4_ff <= res3_ff;
      end
   end

   uer_dist #(
      .CM_DIVISOR (CM_DIVISOR)
   ) u_dist (
      .clock    (clock),
      .en       (dist_en),
      .pulse    (res1_ff.pulse),
      .distance (rsp_distance_cm)
   );

   // ---- response ports ----------------------------------------------------
   assign rsp_valid         = v4_ff;
   assign rsp_trigger_level = res4_ff.trigger;
   assign rsp_busy_res      = res4_ff.busy;
   assign rsp_done_res      = res4_ff.done;
   assign rsp_status        = res4_ff.status;
   assign rsp_pulse_us      = res4_ff.pulse;

endmodule

// ===== hdl/uer_checker.sv =====
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks on the ranger's response stream, bound to the top level.
// ----------------------------------------------------------------------------
module uer_checker
   import uer_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                rsp_trigger_level,
   input  logic                rsp_busy_res,
   input  logic                rsp_done_res,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [REG_W-1:0]    rsp_pulse_us,
   input  logic [DIST_W-1:0]   rsp_distance_cm
);

   // A tick with no result carries no status and no pulse
   a_no_done_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_done_res) |-> (rsp_status == ST_OK && rsp_pulse_us == '0))
      else $error("status or pulse set on a tick without a result");

   // Trigger high and a result only while busy, never on the same tick
   a_trig_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_trigger_level || rsp_done_res))
         |-> (rsp_busy_res && !(rsp_trigger_level && rsp_done_res)))
      else $error("trigger or done outside a busy measurement");

   // A timeout reports no pulse; a zero pulse gives zero distance
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK || rsp_pulse_us == '0))
         |-> (rsp_pulse_us == '0 && rsp_distance_cm == '0))
      else $error("nonzero pulse or distance with timeout or zero pulse");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pulse_us)
         && $stable(rsp_distance_cm) && $stable(rsp_status)))
      else $error("response changed while stalled");

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_trigger_level (rsp_trigger_level),
   .rsp_busy_res      (rsp_busy_res),
   .rsp_done_res      (rsp_done_res),
   .rsp_status        (rsp_status),
   .rsp_pulse_us      (rsp_pulse_us),
   .rsp_distance_cm   (rsp_distance_cm)
);

// ===== tb/ultrasonic_echo_ranger_checker.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_checker
// Watches the tick, response and register ports of the echo ranger, predicts
// every response item from its own copy of the sequencer state and register
// set, and compares each accepted response field by field, in order.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_checker
   import uer_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 20,
   parameter int unsigned CM_DIVISOR  = 5882
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_echo_level,
   input  logic                 req_start_req,

   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_trigger_level,
   input  logic                 rsp_busy_res,
   input  logic                 rsp_done_res,
   input  logic [STATUS_W-1:0]  rsp_status,
   input  logic [REG_W-1:0]     rsp_pulse_us,
   input  logic [DIST_W-1:0]    rsp_distance_cm,

   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_data,

   output int                   mismatch_count,
   output int                   outstanding_ticks,
   output logic                 ranger_idle
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      res_type           res;
      logic [DIST_W-1:0] distance;
   } tick_result_type;

   cfg_type                cfg;
   phase_type              phase;
   logic [COUNT_WIDTH-1:0] tick_cnt;
   tick_result_type        tick_results_q[$];
   int                     errors   = 0;
   int                     rsp_seen = 0;

   function automatic logic [REG_W-1:0] phase_length(phase_type p);
      case (p)
         PH_PRE:  return cfg.pre_low;
         PH_HIGH: return cfg.trigger_high;
         PH_POST: return cfg.post_low;
         default: return REG_W'(1);
      endcase
   endfunction

   // Skip trigger phases of zero length on entry
   function automatic void enter_phase(phase_type p);
      while (p <= PH_POST && phase_length(p) == '0) p = phase_type'(p + 1);
      phase    = p;
      tick_cnt = '0;
   endfunction

   function automatic void close_measurement();
      phase    = (cfg.holdoff == '0) ? PH_IDLE : PH_HOLD;
      tick_cnt = '0;
   endfunction

   function automatic tick_result_type predict_tick(logic echo, logic start);
      tick_result_type r;
      logic [63:0]     dist_val;
      r           = '0;
      r.res.busy  = 1'b1;
      if (phase == PH_IDLE) begin
         if (start) enter_phase(PH_PRE);
         else r.res.busy = 1'b0;
      end
      case (phase)
         PH_PRE, PH_HIGH, PH_POST: begin
            r.res.trigger = (phase == PH_HIGH);
            tick_cnt      = tick_cnt + 1'b1;
            if (tick_cnt >= phase_length(phase)) enter_phase(phase_type'(phase + 1));
         end
         PH_WAIT: begin
            if (echo) begin
               phase    = PH_MEAS;
               tick_cnt = COUNT_WIDTH'(1);
            end else if (tick_cnt >= cfg.timeout) begin
               r.res.done   = 1'b1;
               r.res.status = ST_NO_ECHO;
               close_measurement();
            end else begin
               tick_cnt = tick_cnt + 1'b1;
            end
         end
         PH_MEAS: begin
            if (echo) begin
               if (tick_cnt >= cfg.timeout) begin
                  r.res.done   = 1'b1;
                  r.res.status = ST_TOO_LONG;
                  close_measurement();
               end else begin
                  tick_cnt = tick_cnt + 1'b1;
               end
            end else begin
               r.res.done   = 1'b1;
               r.res.status = ST_OK;
               r.res.pulse  = REG_W'(tick_cnt);
               dist_val = (CM_DIVISOR == 0) ? 64'd0 :
                          (64'(r.res.pulse) * 64'd100) / 64'(CM_DIVISOR);
               if (dist_val > 64'(DIST_MAX)) dist_val = 64'(DIST_MAX);
               r.distance = DIST_W'(dist_val);
               close_measurement();
            end
         end
         PH_HOLD: begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= cfg.holdoff) begin
               phase    = PH_IDLE;
               tick_cnt = '0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t ns: response %0d: %s", $time, rsp_seen, msg);
      errors++;
   endtask

   task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin
      tick_result_type want;
      if (reset) begin
         cfg      = '{pre_low: PRE_LOW_RST, trigger_high: TRIGGER_HIGH_RST,
                      post_low: POST_LOW_RST, timeout: TIMEOUT_RST,
                      holdoff: HOLDOFF_RST};
         phase    = PH_IDLE;
         tick_cnt = '0;
         tick_results_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (tick_results_q.size() == 0) begin
               report_mismatch("response item with no tick waiting for it");
            end else begin
               want = tick_results_q.pop_front();
               compare_field("trigger_level", 32'(rsp_trigger_level),
                             32'(want.res.trigger));
               compare_field("busy_res",      32'(rsp_busy_res), 32'(want.res.busy));
               compare_field("done_res",      32'(rsp_done_res), 32'(want.res.done));
               compare_field("status",        32'(rsp_status),   32'(want.res.status));
               compare_field("pulse_us",      32'(rsp_pulse_us), 32'(want.res.pulse));
               compare_field("distance_cm",   32'(rsp_distance_cm), 32'(want.distance));
            end
            rsp_seen++;
         end
         if (req_valid && !req_stall)
            tick_results_q.push_back(predict_tick(req_echo_level, req_start_req));
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PRE_LOW:      cfg.pre_low      = csr_data;
               CSR_TRIGGER_HIGH: cfg.trigger_high = csr_data;
               CSR_POST_LOW:     cfg.post_low     = csr_data;
               CSR_TIMEOUT:      cfg.timeout      = csr_data;
               CSR_HOLDOFF:      cfg.holdoff      = csr_data;
               default: ;
            endcase
         end
      end
      outstanding_ticks <= tick_results_q.size();
      ranger_idle       <= (phase == PH_IDLE);
      mismatch_count    <= errors;
   end

endmodule

// ===== tb/tb_ultrasonic_echo_ranger_top.sv =====
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger_top
// Stimulus and verdict for the ultrasonic echo ranger. A measurement starts at
// the reset register values and is cut short by lowered limits, a short
// directed part covers zero-length phases, zero and near-limit timeouts and
// starts while busy, and then randomized register settings carry well-formed
// echo sequences mixed with noise ticks.
// Both channels idle and stall at random; the checker does all comparing.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger_top;
   timeunit 1ns;
   timeprecision 1ps;
   import uer_pkg::*;

   localparam int RSP_HOLD_CYCLES = 80;
   localparam int RANDOM_TICKS    = 900;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic                 req_echo_level   = 1'b0;
   logic                 req_start_req    = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic                 rsp_trigger_level;
   logic                 rsp_busy_res;
   logic                 rsp_done_res;
   logic [STATUS_W-1:0]  rsp_status;
   logic [REG_W-1:0]     rsp_pulse_us;
   logic [DIST_W-1:0]    rsp_distance_cm;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [REG_W-1:0]     csr_data         = '0;

   int                   mismatch_count;
   int                   outstanding_ticks;
   logic                 ranger_idle;

   // Stimulus controls shared between the sender and the receiver
   bit                   steady_mode  = 1'b0;
   bit                   rsp_hold_req = 1'b0;
   int                   sent_ticks   = 0;
   cfg_type              cur_cfg;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ultrasonic_echo_ranger_top i_dut (.*);

   ultrasonic_echo_ranger_checker i_checker (.*);

   // Receiver: random stalls, none in steady mode, and one long hold-off on
   // request so the pipeline fills and pushes back on the tick channel.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !steady_mode && ($urandom_range(99) < 15);
         end
      end
   end

   // Offer one tick item, with an optional random gap in front, and hold it
   // until the block takes it. Valid stays high afterwards; the next call
   // either replaces the payload or drops valid.
   task automatic send_tick(input logic echo, input logic start);
      while (!steady_mode && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_echo_level <= echo;
      req_start_req  <= start;
      do @(posedge clock); while (req_stall);
      sent_ticks++;
   endtask

   task automatic send_ticks(input int n, input logic echo, input logic start);
      repeat (n) send_tick(echo, start);
   endtask

   // Drop valid and wait for every outstanding response item.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding_ticks != 0);
   endtask

   // Send quiet ticks until the ranger is back in idle, then drop valid and
   // wait for every outstanding response item. The idle flag is registered, so
   // always send at least one tick before trusting it.
   task automatic settle_idle();
      do send_tick(1'($urandom_range(1)), 1'b0); while (!ranger_idle);
      drain();
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= value;
      @(posedge clock);
   endtask

   // Program the whole register set; finish with a write to an undecoded
   // index, which must leave every register alone.
   task automatic program_cfg(input cfg_type c);
      cur_cfg = c;
      write_reg(CSR_PRE_LOW,      c.pre_low);
      write_reg(CSR_TRIGGER_HIGH, c.trigger_high);
      write_reg(CSR_POST_LOW,     c.post_low);
      write_reg(CSR_TIMEOUT,      c.timeout);
      write_reg(CSR_HOLDOFF,      c.holdoff);
      write_reg(CSR_IDX_W'($urandom_range(CSR_HOLDOFF + 1, {CSR_IDX_W{1'b1}})),
                REG_W'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   // One well-formed measurement: wait for idle, start, ride out the trigger
   // phases with junk on the echo pin, hold echo low, then high, then drop it.
   task automatic run_measurement(input int unsigned rise_after,
                                  input int unsigned high_ticks);
      int unsigned lead;
      lead = cur_cfg.pre_low + cur_cfg.trigger_high + cur_cfg.post_low;
      do send_tick(1'($urandom_range(1)), 1'b0); while (!ranger_idle);
      send_tick(1'($urandom_range(1)), 1'b1);
      if (lead > 0)
         repeat (lead - 1) send_tick(1'($urandom_range(1)), $urandom_range(99) < 20);
      repeat (rise_after) send_tick(1'b0, $urandom_range(99) < 10);
      repeat (high_ticks) send_tick(1'b1, $urandom_range(99) < 10);
      send_tick(1'b0, $urandom_range(99) < 10);
   endtask

   // Mostly short lengths; often land right around a small limit so both
   // timeout edges get hit.
   function automatic int unsigned pick_len(input int unsigned limit, input int unsigned span);
      if (limit <= 64 && $urandom_range(99) < 30)
         return (limit == 0) ? $urandom_range(2) : limit - 1 + $urandom_range(2);
      return $urandom_range(span);
   endfunction

   function automatic cfg_type random_cfg(input bit wide_timeout);
      cfg_type c;
      c.pre_low      = REG_W'($urandom_range(4));
      c.trigger_high = ($urandom_range(9) == 0) ? '0 : REG_W'($urandom_range(1, 4));
      c.post_low     = REG_W'($urandom_range(4));
      c.timeout      = wide_timeout ? {REG_W{1'b1}} : REG_W'($urandom_range(12));
      c.holdoff      = REG_W'($urandom_range(6));
      return c;
   endfunction

   initial begin
      int random_base;
      int phase_no;
      cur_cfg = '{pre_low: PRE_LOW_RST, trigger_high: TRIGGER_HIGH_RST,
                  post_low: POST_LOW_RST, timeout: TIMEOUT_RST, holdoff: HOLDOFF_RST};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset register values: start and ride part of the long pre-low phase,
      // then lower the limits below; the running phase ends on the next tick.
      send_tick(1'b0, 1'b1);
      send_ticks(20, 1'b0, 1'b0);
      drain();

      // Shortest trigger: pulse of two, no echo past the limit, echo too long.
      // Starts land on busy ticks and must be dropped.
      program_cfg('{pre_low: '0, trigger_high: REG_W'(1), post_low: '0,
                    timeout: REG_W'(3), holdoff: '0});
      settle_idle();
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_ticks(5, 1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_ticks(5, 1'b1, 1'b0);
      settle_idle();

      // All trigger phases empty and a zero timeout: the start tick already
      // watches the echo and fails at once; starts during holdoff are dropped.
      program_cfg('{pre_low: '0, trigger_high: '0, post_low: '0, timeout: '0,
                    holdoff: REG_W'(2)});
      send_tick(1'b0, 1'b1);
      send_ticks(2, 1'b0, 1'b1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_ticks(2, 1'b0, 1'b0);
      settle_idle();

      // Every register at full scale; idle ticks only
      program_cfg('{pre_low: '1, trigger_high: '1, post_low: '1, timeout: '1, holdoff: '1});
      send_ticks(2, 1'b1, 1'b0);
      send_ticks(2, 1'b0, 1'b0);
      settle_idle();

      // Random settings. Phase 1 runs with no idling on either side, phase 2
      // opens with a long receiver hold-off, phase 3 uses the widest timeout
      // and one long pulse for a distance of several centimeters.
      random_base = sent_ticks;
      phase_no    = 0;
      while (sent_ticks - random_base < RANDOM_TICKS) begin
         program_cfg(random_cfg(phase_no == 3));
         steady_mode = (phase_no == 1);
         if (phase_no == 2) rsp_hold_req = 1'b1;
         if (phase_no == 3) run_measurement($urandom_range(12), $urandom_range(200, 300));
         repeat ($urandom_range(3, 8)) begin
            if ($urandom_range(99) < 15)
               repeat ($urandom_range(2, 10))
                  send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            else
               run_measurement(pick_len(cur_cfg.timeout, 12), pick_len(cur_cfg.timeout, 12));
         end
         settle_idle();
         phase_no++;
      end
      steady_mode = 1'b0;

      // Let any stray response surface before the verdict
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && outstanding_ticks == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule
